@@ hw/rtl/cell_report_line_parser_defines.svh @@
// assertion macros for the cell report line parser checker
// no dependencies; taken in by the checker file only
`ifndef CELL_REPORT_LINE_PARSER_DEFINES_SVH
`define CELL_REPORT_LINE_PARSER_DEFINES_SVH

// same-cycle implication, switched off while reset is high
`define CRLP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off while reset is high
`define CRLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/crlp_pkg.sv @@
// shared types, constants and decode functions of the cell report line parser
// no dependencies
package crlp_pkg;

  localparam int unsigned DEF_TOWER_SLOTS   = 7;
  localparam int unsigned DEF_PREFIX_WINDOW = 50;
  localparam int unsigned DEF_QUEUE_DEPTH   = 4;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [2:0] PREFIX_LEN           = 3'd6;
  localparam logic [7:0] MIN_LINE_LEN         = 8'd15;
  localparam logic [7:0] LEVEL_OFFSET         = 8'd113;
  localparam logic [3:0] SERVING_LAST_FIELD   = 4'd10;
  localparam logic [3:0] NEIGHBOUR_LAST_FIELD = 4'd6;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_SKIP   = 3'd1,
    PH_INDEX  = 3'd2,
    PH_QUOTE  = 3'd3,
    PH_GAP    = 3'd4,
    PH_TOKEN  = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    SLOT_RXL  = 3'd0,
    SLOT_MCC  = 3'd1,
    SLOT_MNC  = 3'd2,
    SLOT_CID  = 3'd3,
    SLOT_LAC  = 3'd4,
    SLOT_TA   = 3'd5,
    SLOT_NONE = 3'd6
  } slot_t;

  // one classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0]        data_byte;
    logic              last;
    logic              is_zero;
    logic              is_quote;
    logic              is_comma;
    logic              is_plus;
    logic              hex_ok;
    logic [3:0]        hex_val;
    logic signed [8:0] dec_term;
  } class_word_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (pos)
      3'd0:    c = 8'h2B;  // +
      3'd1:    c = 8'h43;  // C
      3'd2:    c = 8'h45;  // E
      3'd3:    c = 8'h4E;  // N
      3'd4:    c = 8'h47;  // G
      3'd5:    c = 8'h3A;  // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // token position to capture slot, serving and neighbour layouts
  function automatic slot_t slot_of(input logic serving, input logic [3:0] fn);
    slot_t s;
    s = SLOT_NONE;
    if (serving) begin
      unique case (fn)
        4'd1:    s = SLOT_RXL;
        4'd3:    s = SLOT_MCC;
        4'd4:    s = SLOT_MNC;
        4'd6:    s = SLOT_CID;
        4'd9:    s = SLOT_LAC;
        4'd10:   s = SLOT_TA;
        default: s = SLOT_NONE;
      endcase
    end else begin
      unique case (fn)
        4'd1:    s = SLOT_RXL;
        4'd3:    s = SLOT_CID;
        4'd4:    s = SLOT_MCC;
        4'd5:    s = SLOT_MNC;
        4'd6:    s = SLOT_LAC;
        default: s = SLOT_NONE;
      endcase
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/crlp_if.sv @@
// channel interfaces of the cell report line parser: line bytes, config, records
// no dependencies
interface crlp_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_last;
  modport source (output valid, line_byte, line_last, input ready);
  modport sink (input valid, line_byte, line_last, output ready);
endinterface

interface crlp_cfg_if;
  logic valid;
  logic ready;
  logic report_enable;
  modport source (output valid, report_enable, input ready);
  modport sink (input valid, report_enable, output ready);
endinterface

interface crlp_rec_if;
  logic               valid;
  logic               ready;
  logic               entry_valid;
  logic [3:0]         tower_index;
  logic signed [7:0]  signal_dbm;
  logic [15:0]        country_code;
  logic signed [7:0]  network_code;
  logic [31:0]        cell_ident;
  logic [15:0]        area_code;
  logic [15:0]        timing_advance;
  logic               set_complete;
  logic               serving_changed;
  modport source (
    output valid, entry_valid, tower_index, signal_dbm, country_code, network_code,
           cell_ident, area_code, timing_advance, set_complete, serving_changed,
    input  ready
  );
  modport sink (
    input  valid, entry_valid, tower_index, signal_dbm, country_code, network_code,
           cell_ident, area_code, timing_advance, set_complete, serving_changed,
    output ready
  );
endinterface

@@ hw/rtl/crlp_front.sv @@
// front end: takes line bytes and classifies each into a queue word
// depends on crlp_pkg and crlp_if
module crlp_front (
  crlp_line_if.sink                line,
  output logic                     push_valid,
  input  logic                     push_ready,
  output crlp_pkg::class_word_t    push_word
);

  logic [7:0] b;
  logic       is_digit;
  logic       is_lower;
  logic       is_upper;

  assign b        = line.line_byte;
  assign is_digit = (b >= crlp_pkg::CHAR_ZERO) && (b <= crlp_pkg::CHAR_NINE);
  assign is_lower = (b >= 8'h61) && (b <= 8'h66);
  assign is_upper = (b >= 8'h41) && (b <= 8'h46);

  assign line.ready = push_ready;
  assign push_valid = line.valid;

  always_comb begin
    push_word.data_byte = b;
    push_word.last      = line.line_last;
    push_word.is_zero   = (b == 8'h00);
    push_word.is_quote  = (b == crlp_pkg::CHAR_QUOTE);
    push_word.is_comma  = (b == crlp_pkg::CHAR_COMMA);
    push_word.is_plus   = (b == crlp_pkg::CHAR_PLUS);
    push_word.hex_ok    = is_digit | is_lower | is_upper;
    // letters a-f and A-F both have low nibble 1..6, so adding 9 gives 10..15
    push_word.hex_val   = is_digit ? b[3:0] : 4'(b[3:0] + 4'd9);
    // byte read as signed, minus ascii zero
    push_word.dec_term  = $signed({b[7], b}) - 9'sd48;
  end

endmodule

@@ hw/rtl/crlp_queue.sv @@
// short word queue between the front and back ends
// depends on crlp_pkg
module crlp_queue #(
  parameter int unsigned DEPTH = crlp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  crlp_pkg::class_word_t push_word,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output crlp_pkg::class_word_t pop_word
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  crlp_pkg::class_word_t entries [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      fill;
  logic                  push;
  logic                  pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_word   = entries[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule

@@ hw/rtl/crlp_back.sv @@
// back end: line parser state machine, accumulators, captures and record register
// depends on crlp_pkg and crlp_if
module crlp_back #(
  parameter int unsigned TOWER_SLOTS   = crlp_pkg::DEF_TOWER_SLOTS,
  parameter int unsigned PREFIX_WINDOW = crlp_pkg::DEF_PREFIX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  crlp_pkg::class_word_t pop_word,
  input  logic                  report_enable,
  crlp_rec_if.source            rec
);

  localparam logic [7:0] INDEX_LIMIT = 8'(int'(crlp_pkg::CHAR_ZERO) + TOWER_SLOTS);
  localparam logic [3:0] LAST_SLOT   = 4'(TOWER_SLOTS - 1);
  localparam logic [7:0] WINDOW      = 8'(PREFIX_WINDOW);

  crlp_pkg::phase_t phase, phase_next;
  logic [7:0]       byte_count, byte_count_next;
  logic [2:0]       prefix_progress, prefix_progress_next;
  logic [3:0]       field_number, field_number_next;
  logic [3:0]       index_held, index_held_next;
  logic [31:0]      decimal_accum, decimal_accum_next;
  logic [31:0]      hex_accum, hex_accum_next;
  logic             line_bad, line_bad_next;
  logic [7:0]       cap_rxl, cap_rxl_next;
  logic [15:0]      cap_mcc, cap_mcc_next;
  logic [7:0]       cap_mnc, cap_mnc_next;
  logic [31:0]      cap_cid, cap_cid_next;
  logic [15:0]      cap_lac, cap_lac_next;
  logic [15:0]      cap_ta, cap_ta_next;
  logic [31:0]      last_serving_id;

  logic             pop;
  logic             finish;
  logic             is_delim;
  logic [3:0]       last_field;
  logic [31:0]      dec_ext;
  logic [31:0]      dec_grown;
  logic [31:0]      hex_grown;
  crlp_pkg::slot_t  slot;
  logic             line_ok;
  logic             serving;

  assign pop_ready = ~rec.valid | rec.ready;
  assign pop       = pop_valid & pop_ready;

  assign last_field = (index_held == 4'd0) ? crlp_pkg::SERVING_LAST_FIELD
                                           : crlp_pkg::NEIGHBOUR_LAST_FIELD;
  assign is_delim   = (field_number >= last_field) ? pop_word.is_quote : pop_word.is_comma;
  assign dec_ext    = {{23{pop_word.dec_term[8]}}, pop_word.dec_term};
  assign dec_grown  = (decimal_accum << 3) + (decimal_accum << 1) + dec_ext;
  assign hex_grown  = pop_word.hex_ok ? {hex_accum[27:0], pop_word.hex_val} : hex_accum;

  always_comb begin
    phase_next           = phase;
    byte_count_next      = (byte_count == 8'hFF) ? byte_count : byte_count + 8'd1;
    prefix_progress_next = prefix_progress;
    field_number_next    = field_number;
    index_held_next      = index_held;
    decimal_accum_next   = decimal_accum;
    hex_accum_next       = hex_accum;
    line_bad_next        = line_bad;
    finish               = 1'b0;

    unique case (phase)
      crlp_pkg::PH_SEARCH: begin
        if (pop_word.is_zero || byte_count >= WINDOW) begin
          line_bad_next = 1'b1;
          phase_next    = crlp_pkg::PH_DONE;
        end else begin
          if (prefix_progress < crlp_pkg::PREFIX_LEN &&
              pop_word.data_byte == crlp_pkg::prefix_char(prefix_progress)) begin
            prefix_progress_next = prefix_progress + 3'd1;
          end else begin
            prefix_progress_next = pop_word.is_plus ? 3'd1 : 3'd0;
          end
          if (prefix_progress_next >= crlp_pkg::PREFIX_LEN) begin
            phase_next = crlp_pkg::PH_SKIP;
          end
        end
      end
      crlp_pkg::PH_SKIP: begin
        if (pop_word.is_zero) begin
          line_bad_next = 1'b1;
          phase_next    = crlp_pkg::PH_DONE;
        end else begin
          phase_next = crlp_pkg::PH_INDEX;
        end
      end
      crlp_pkg::PH_INDEX: begin
        if (pop_word.data_byte < crlp_pkg::CHAR_ZERO || pop_word.data_byte >= INDEX_LIMIT) begin
          line_bad_next = 1'b1;
          phase_next    = crlp_pkg::PH_DONE;
        end else begin
          index_held_next = 4'(pop_word.data_byte - crlp_pkg::CHAR_ZERO);
          phase_next      = crlp_pkg::PH_QUOTE;
        end
      end
      crlp_pkg::PH_QUOTE: begin
        if (pop_word.is_zero) begin
          phase_next = crlp_pkg::PH_DONE;
        end else if (pop_word.is_quote) begin
          phase_next = crlp_pkg::PH_GAP;
        end
      end
      crlp_pkg::PH_GAP: begin
        if (pop_word.is_zero) begin
          phase_next = crlp_pkg::PH_DONE;
        end else if (!is_delim) begin
          decimal_accum_next = dec_ext;
          hex_accum_next     = pop_word.hex_ok ? 32'(pop_word.hex_val) : 32'd0;
          phase_next         = crlp_pkg::PH_TOKEN;
        end
      end
      crlp_pkg::PH_TOKEN: begin
        if (pop_word.is_zero) begin
          finish     = 1'b1;
          phase_next = crlp_pkg::PH_DONE;
        end else if (is_delim) begin
          finish = 1'b1;
          if (field_number >= last_field) begin
            phase_next = crlp_pkg::PH_DONE;
          end else begin
            field_number_next = field_number + 4'd1;
            phase_next        = crlp_pkg::PH_GAP;
          end
        end else begin
          decimal_accum_next = dec_grown;
          hex_accum_next     = hex_grown;
        end
      end
      crlp_pkg::PH_DONE: begin
        phase_next = crlp_pkg::PH_DONE;
      end
      default: begin
        phase_next = crlp_pkg::PH_DONE;
      end
    endcase

    // an open token is closed at line end
    if (pop_word.last && phase_next == crlp_pkg::PH_TOKEN) begin
      finish = 1'b1;
    end
  end

  always_comb begin
    slot         = finish ? crlp_pkg::slot_of(index_held == 4'd0, field_number)
                          : crlp_pkg::SLOT_NONE;
    cap_rxl_next = cap_rxl;
    cap_mcc_next = cap_mcc;
    cap_mnc_next = cap_mnc;
    cap_cid_next = cap_cid;
    cap_lac_next = cap_lac;
    cap_ta_next  = cap_ta;
    unique case (slot)
      crlp_pkg::SLOT_RXL:  cap_rxl_next = decimal_accum_next[7:0];
      crlp_pkg::SLOT_MCC:  cap_mcc_next = decimal_accum_next[15:0];
      crlp_pkg::SLOT_MNC:  cap_mnc_next = decimal_accum_next[7:0];
      crlp_pkg::SLOT_CID:  cap_cid_next = hex_accum_next;
      crlp_pkg::SLOT_LAC:  cap_lac_next = hex_accum_next[15:0];
      crlp_pkg::SLOT_TA:   cap_ta_next  = decimal_accum_next[15:0];
      crlp_pkg::SLOT_NONE: cap_ta_next  = cap_ta;
      default:             cap_ta_next  = cap_ta;
    endcase

    line_ok = ~line_bad_next && byte_count_next >= crlp_pkg::MIN_LINE_LEN &&
              (phase_next == crlp_pkg::PH_QUOTE || phase_next == crlp_pkg::PH_GAP ||
               phase_next == crlp_pkg::PH_TOKEN || phase_next == crlp_pkg::PH_DONE);
    serving = (index_held_next == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= crlp_pkg::PH_SEARCH;
      byte_count      <= '0;
      prefix_progress <= '0;
      field_number    <= '0;
      index_held      <= '0;
      decimal_accum   <= '0;
      hex_accum       <= '0;
      line_bad        <= 1'b0;
      cap_rxl         <= '0;
      cap_mcc         <= '0;
      cap_mnc         <= '0;
      cap_cid         <= '0;
      cap_lac         <= '0;
      cap_ta          <= '0;
      last_serving_id <= '0;
    end else if (pop) begin
      if (pop_word.last) begin
        phase           <= crlp_pkg::PH_SEARCH;
        byte_count      <= '0;
        prefix_progress <= '0;
        field_number    <= '0;
        index_held      <= '0;
        decimal_accum   <= '0;
        hex_accum       <= '0;
        line_bad        <= 1'b0;
        cap_rxl         <= '0;
        cap_mcc         <= '0;
        cap_mnc         <= '0;
        cap_cid         <= '0;
        cap_lac         <= '0;
        cap_ta          <= '0;
        if (line_ok && serving) begin
          last_serving_id <= cap_cid_next;
        end
      end else begin
        phase           <= phase_next;
        byte_count      <= byte_count_next;
        prefix_progress <= prefix_progress_next;
        field_number    <= field_number_next;
        index_held      <= index_held_next;
        decimal_accum   <= decimal_accum_next;
        hex_accum       <= hex_accum_next;
        line_bad        <= line_bad_next;
        cap_rxl         <= cap_rxl_next;
        cap_mcc         <= cap_mcc_next;
        cap_mnc         <= cap_mnc_next;
        cap_cid         <= cap_cid_next;
        cap_lac         <= cap_lac_next;
        cap_ta          <= cap_ta_next;
      end
    end
  end

  // record register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else if (pop && pop_word.last) begin
      rec.valid <= 1'b1;
    end else if (rec.ready) begin
      rec.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_word.last) begin
      rec.entry_valid     <= line_ok;
      rec.tower_index     <= line_ok ? index_held_next : 4'd0;
      rec.signal_dbm      <= line_ok ? $signed(cap_rxl_next - crlp_pkg::LEVEL_OFFSET) : 8'sd0;
      rec.country_code    <= line_ok ? cap_mcc_next : 16'd0;
      rec.network_code    <= line_ok ? $signed(cap_mnc_next) : 8'sd0;
      rec.cell_ident      <= line_ok ? cap_cid_next : 32'd0;
      rec.area_code       <= line_ok ? cap_lac_next : 16'd0;
      rec.timing_advance  <= (line_ok && serving) ? cap_ta_next : 16'd0;
      rec.set_complete    <= line_ok && report_enable && (index_held_next == LAST_SLOT);
      rec.serving_changed <= line_ok && serving && (cap_cid_next != last_serving_id);
    end
  end

endmodule

@@ hw/rtl/cell_report_line_parser.sv @@
// top level of the cell report line parser: front, queue, back and config register
// depends on crlp_pkg, crlp_if, crlp_front, crlp_queue and crlp_back
//
//   channel  dir  carries                               moves on
//   line     in   line_byte, line_last                  valid & ready
//   cfg      in   report_enable                         valid & ready (ready tied high)
//   rec      out  one record per line, ten fields       valid & ready
//
// one byte word a cycle sustained while rec is taken; the back end state machine and
// its multiply-by-ten and shift-by-four accumulators process one word a cycle
// a record becomes valid once its last byte word has gone through the queue into the record register
// rst clears the queue, parse state, last serving cell id and report_enable; no
// clearing pass, the block takes words from the first cycle after reset
// a stalled rec holds the back end; the queue then fills and line.ready falls after
// at most QUEUE_DEPTH more words
module cell_report_line_parser #(
  parameter int unsigned TOWER_SLOTS   = crlp_pkg::DEF_TOWER_SLOTS,
  parameter int unsigned PREFIX_WINDOW = crlp_pkg::DEF_PREFIX_WINDOW,
  parameter int unsigned QUEUE_DEPTH   = crlp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  crlp_line_if.sink   line,
  crlp_cfg_if.sink    cfg,
  crlp_rec_if.source  rec
);

  // front to queue
  logic                  push_valid;
  logic                  push_ready;
  crlp_pkg::class_word_t push_word;

  // queue to back
  logic                  pop_valid;
  logic                  pop_ready;
  crlp_pkg::class_word_t pop_word;

  // consumer enable, used when a record is formed
  logic                  report_enable;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_enable <= 1'b0;
    end else if (cfg.valid) begin
      report_enable <= cfg.report_enable;
    end
  end

  // byte classification
  crlp_front u_front (
    .line       (line),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  // decouples input stalls from record stalls
  crlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  // parser and record register
  crlp_back #(
    .TOWER_SLOTS   (TOWER_SLOTS),
    .PREFIX_WINDOW (PREFIX_WINDOW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_word      (pop_word),
    .report_enable (report_enable),
    .rec           (rec)
  );

endmodule

@@ hw/rtl/crlp_checker.sv @@
// port level checks on records of the cell report line parser, bound to the top level
// depends on crlp_pkg and cell_report_line_parser_defines.svh
`include "cell_report_line_parser_defines.svh"

module crlp_checker #(
  parameter int unsigned TOWER_SLOTS = crlp_pkg::DEF_TOWER_SLOTS
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              entry_valid,
  input logic [3:0]        tower_index,
  input logic signed [7:0] signal_dbm,
  input logic [31:0]       cell_ident,
  input logic [15:0]       timing_advance,
  input logic              set_complete,
  input logic              serving_changed
);

  localparam logic [3:0] LAST_SLOT = 4'(TOWER_SLOTS - 1);

  `CRLP_ASSERT_NEXT(a_rec_held, clk, rst, out_valid && !out_ready, out_valid, "record dropped while stalled")

  `CRLP_ASSERT_NOW(a_bad_line_zero, clk, rst, out_valid && !entry_valid, tower_index == 4'd0 && signal_dbm == 8'sd0 && cell_ident == 32'd0 && !set_complete && !serving_changed, "invalid record carries data")

  `CRLP_ASSERT_NOW(a_neighbour_no_ta, clk, rst, out_valid && entry_valid && tower_index != 4'd0, timing_advance == 16'd0 && !serving_changed, "neighbour record with serving fields")

  `CRLP_ASSERT_NOW(a_complete_last, clk, rst, out_valid && set_complete, entry_valid && tower_index == LAST_SLOT, "set complete on wrong slot")

  `CRLP_ASSERT_NOW(a_index_range, clk, rst, out_valid && entry_valid, tower_index <= LAST_SLOT, "tower index out of range")

endmodule

bind cell_report_line_parser crlp_checker #(
  .TOWER_SLOTS (TOWER_SLOTS)
) u_crlp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (rec.valid),
  .out_ready       (rec.ready),
  .entry_valid     (rec.entry_valid),
  .tower_index     (rec.tower_index),
  .signal_dbm      (rec.signal_dbm),
  .cell_ident      (rec.cell_ident),
  .timing_advance  (rec.timing_advance),
  .set_complete    (rec.set_complete),
  .serving_changed (rec.serving_changed)
);

@@ tb/sv/crlp_record_checker.sv @@
`timescale 1ns / 1ps
// record checker for the cell report line parser: follows each byte word taken,
// predicts the one record per line and compares it with the record channel
// depends on crlp_pkg and the channel interfaces of crlp_if
module crlp_record_checker (
  input  logic  clk,
  input  logic  rst,
  crlp_line_if  line,
  crlp_cfg_if   cfg,
  crlp_rec_if   rec,
  output int    mismatches,
  output int    pending
);
  import crlp_pkg::*;

  localparam logic [47:0] REPORT_TAG  = "+CENG:";
  localparam logic [7:0]  INDEX_LIMIT = CHAR_ZERO + 8'(DEF_TOWER_SLOTS);
  localparam logic [3:0]  LAST_SLOT   = 4'(DEF_TOWER_SLOTS - 1);
  localparam logic [7:0]  CH_UP_A     = 8'h41;
  localparam logic [7:0]  CH_UP_F     = 8'h46;
  localparam logic [7:0]  CH_LO_A     = 8'h61;
  localparam logic [7:0]  CH_LO_F     = 8'h66;

  typedef struct packed {
    logic        entry_valid;
    logic [3:0]  tower_index;
    logic [7:0]  signal_dbm;
    logic [15:0] country_code;
    logic [7:0]  network_code;
    logic [31:0] cell_ident;
    logic [15:0] area_code;
    logic [15:0] timing_advance;
    logic        set_complete;
    logic        serving_changed;
  } cell_record_t;

  // predicted parser state
  logic        report_en;
  logic [7:0]  byte_cnt;
  logic [2:0]  tag_pos;
  phase_t      phase;
  logic [3:0]  field_no;
  logic [3:0]  tower;
  logic [31:0] dec_acc;
  logic [31:0] hex_acc;
  logic [31:0] captured [6];
  logic [31:0] last_cell_id;
  logic        line_bad;

  cell_record_t expected_records [$];
  int errs = 0;
  int n_pending = 0;

  assign mismatches = errs;
  assign pending    = n_pending;

  function automatic logic [3:0] closing_field();
    return (tower == 4'd0) ? SERVING_LAST_FIELD : NEIGHBOUR_LAST_FIELD;
  endfunction

  // the last token ends at a quote, all others at a comma
  function automatic logic [7:0] field_delim();
    return (field_no >= closing_field()) ? CHAR_QUOTE : CHAR_COMMA;
  endfunction

  task clear_line_state;
    int k;
    byte_cnt = '0;
    tag_pos  = '0;
    phase    = PH_SEARCH;
    field_no = '0;
    tower    = '0;
    dec_acc  = '0;
    hex_acc  = '0;
    for (k = 0; k < 6; k++) captured[k] = '0;
    line_bad = 1'b0;
  endtask

  task add_char(input logic [7:0] c);
    dec_acc = dec_acc * 32'd10 + {{24{c[7]}}, c} - 32'(CHAR_ZERO);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      hex_acc = {hex_acc[27:0], 4'(c - CHAR_ZERO)};
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      hex_acc = {hex_acc[27:0], 4'(c - CH_LO_A + 8'd10)};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      hex_acc = {hex_acc[27:0], 4'(c - CH_UP_A + 8'd10)};
    end
  endtask

  task close_token;
    slot_t s;
    s = SLOT_NONE;
    if (tower == 4'd0) begin
      case (field_no)
        4'd1:    s = SLOT_RXL;
        4'd3:    s = SLOT_MCC;
        4'd4:    s = SLOT_MNC;
        4'd6:    s = SLOT_CID;
        4'd9:    s = SLOT_LAC;
        4'd10:   s = SLOT_TA;
        default: s = SLOT_NONE;
      endcase
    end else begin
      case (field_no)
        4'd1:    s = SLOT_RXL;
        4'd3:    s = SLOT_CID;
        4'd4:    s = SLOT_MCC;
        4'd5:    s = SLOT_MNC;
        4'd6:    s = SLOT_LAC;
        default: s = SLOT_NONE;
      endcase
    end
    if (s == SLOT_CID || s == SLOT_LAC) begin
      captured[s] = hex_acc;
    end else if (s != SLOT_NONE) begin
      captured[s] = dec_acc;
    end
    if (field_no >= closing_field()) begin
      phase = PH_DONE;
    end else begin
      field_no = field_no + 4'd1;
      phase    = PH_GAP;
    end
  endtask

  task compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: record field %s mismatch, expected 0x%0h, got 0x%0h",
               $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    cell_record_t want;
    logic [7:0]   c;
    logic [7:0]   pos;
    if (rst) begin
      clear_line_state();
      report_en    = 1'b0;
      last_cell_id = '0;
      expected_records.delete();
    end else begin
      if (cfg.valid && cfg.ready) report_en = cfg.report_enable;

      if (line.valid && line.ready) begin
        c   = line.line_byte;
        pos = byte_cnt;
        if (byte_cnt != 8'hFF) byte_cnt = byte_cnt + 8'd1;
        case (phase)
          PH_SEARCH: begin
            if (c == 8'h00 || pos >= DEF_PREFIX_WINDOW) begin
              line_bad = 1'b1;
              phase    = PH_DONE;
            end else begin
              if (tag_pos < PREFIX_LEN && c == REPORT_TAG[47 - 8 * tag_pos -: 8]) begin
                tag_pos = tag_pos + 3'd1;
              end else begin
                tag_pos = (c == CHAR_PLUS) ? 3'd1 : 3'd0;
              end
              if (tag_pos >= PREFIX_LEN) phase = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (c == 8'h00) begin
              line_bad = 1'b1;
              phase    = PH_DONE;
            end else begin
              phase = PH_INDEX;
            end
          end
          PH_INDEX: begin
            if (c < CHAR_ZERO || c >= INDEX_LIMIT) begin
              line_bad = 1'b1;
              phase    = PH_DONE;
            end else begin
              tower = 4'(c - CHAR_ZERO);
              phase = PH_QUOTE;
            end
          end
          PH_QUOTE: begin
            if (c == 8'h00) phase = PH_DONE;
            else if (c == CHAR_QUOTE) phase = PH_GAP;
          end
          PH_GAP: begin
            if (c == 8'h00) begin
              phase = PH_DONE;
            end else if (c != field_delim()) begin
              dec_acc = '0;
              hex_acc = '0;
              add_char(c);
              phase = PH_TOKEN;
            end
          end
          PH_TOKEN: begin
            if (c == 8'h00) begin
              close_token();
              phase = PH_DONE;
            end else if (c == field_delim()) begin
              close_token();
            end else begin
              add_char(c);
            end
          end
          default: ;
        endcase

        if (line.line_last) begin
          if (phase == PH_TOKEN) close_token();
          want = '0;
          if (!line_bad && phase >= PH_QUOTE && byte_cnt >= MIN_LINE_LEN) begin
            want.entry_valid  = 1'b1;
            want.tower_index  = tower;
            want.signal_dbm   = captured[SLOT_RXL][7:0] - LEVEL_OFFSET;
            want.country_code = captured[SLOT_MCC][15:0];
            want.network_code = captured[SLOT_MNC][7:0];
            want.cell_ident   = captured[SLOT_CID];
            want.area_code    = captured[SLOT_LAC][15:0];
            want.set_complete = report_en && (tower == LAST_SLOT);
            if (tower == 4'd0) begin
              want.timing_advance  = captured[SLOT_TA][15:0];
              want.serving_changed = (captured[SLOT_CID] != last_cell_id);
              last_cell_id         = captured[SLOT_CID];
            end
          end
          expected_records.push_back(want);
          clear_line_state();
        end
      end

      if (rec.valid && rec.ready) begin
        if (expected_records.size() == 0) begin
          $display("%0t: record with no line waiting, expected none, got valid %0b id 0x%0h",
                   $time, rec.entry_valid, rec.cell_ident);
          errs++;
        end else begin
          want = expected_records.pop_front();
          compare_field("entry_valid", 32'(want.entry_valid), 32'(rec.entry_valid));
          compare_field("tower_index", 32'(want.tower_index), 32'(rec.tower_index));
          compare_field("signal_dbm", 32'(want.signal_dbm),
                        32'($unsigned(rec.signal_dbm)));
          compare_field("country_code", 32'(want.country_code), 32'(rec.country_code));
          compare_field("network_code", 32'(want.network_code),
                        32'($unsigned(rec.network_code)));
          compare_field("cell_ident", want.cell_ident, rec.cell_ident);
          compare_field("area_code", 32'(want.area_code), 32'(rec.area_code));
          compare_field("timing_advance", 32'(want.timing_advance),
                        32'(rec.timing_advance));
          compare_field("set_complete", 32'(want.set_complete), 32'(rec.set_complete));
          compare_field("serving_changed", 32'(want.serving_changed),
                        32'(rec.serving_changed));
        end
      end
    end
    n_pending = expected_records.size();
  end

endmodule

@@ tb/sv/cell_report_line_parser_tb.sv @@
`timescale 1ns / 1ps
// top of the cell report line parser bench: clock, reset, line and config stimulus,
// record back-pressure and the verdict
// depends on crlp_pkg, crlp_if, the parser rtl and crlp_record_checker
module cell_report_line_parser_tb;
  import crlp_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int TOTAL_BYTES  = 1500;
  localparam int IDLE_PCT     = 22;

  logic clk = 1'b0;
  logic rst;

  crlp_line_if line_ch ();
  crlp_cfg_if  cfg_ch ();
  crlp_rec_if  rec_ch ();

  cell_report_line_parser u_dut (
    .clk  (clk),
    .rst  (rst),
    .line (line_ch),
    .cfg  (cfg_ch),
    .rec  (rec_ch)
  );

  int fails;
  int waiting;

  crlp_record_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .line       (line_ch),
    .cfg        (cfg_ch),
    .rec        (rec_ch),
    .mismatches (fails),
    .pending    (waiting)
  );

  // bytes of the line about to go out
  logic [7:0] line_buf [$];
  string      hex_chars = "0123456789abcdefABCDEF";
  bit         calm = 1'b0;
  int         bytes_sent = 0;
  int         cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog, reckoned well past the slowest correct run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // record side back-pressure, off during calm stretches
  always @(negedge clk) begin
    rec_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // one byte word per handshake, random gaps before each word
  task send_line;
    int i;
    for (i = 0; i < line_buf.size(); i++) begin
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
        @(negedge clk);
        line_ch.valid <= 1'b0;
      end
      @(negedge clk);
      line_ch.valid     <= 1'b1;
      line_ch.line_byte <= line_buf[i];
      line_ch.line_last <= (i == line_buf.size() - 1);
      do @(posedge clk); while (!line_ch.ready);
      bytes_sent++;
    end
  endtask

  task send_text(input string s);
    line_buf.delete();
    add_text(s);
    send_line();
  endtask

  // hold the line channel until every record is back, then let the pipe empty
  task settle_records;
    @(negedge clk);
    line_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // only called with the block idle
  task write_report_enable(input bit en);
    @(negedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.report_enable <= en;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task add_token(input bit hexy);
    int r;
    r = $urandom_range(99);
    if (hexy && r < 45) begin
      // hex with the odd stray character, short ids repeat often
      repeat ($urandom_range(1, 9)) begin
        if ($urandom_range(9) == 0) line_buf.push_back("-");
        line_buf.push_back(hex_chars[$urandom_range(21)]);
      end
    end else if (r < 75) begin
      repeat ($urandom_range(1, 4)) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    end else if (r < 87) begin
      // nine to twelve digits, long enough at the top end to wrap the decimal accumulator
      repeat ($urandom_range(9, 12)) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    end else if (r < 95) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(8'h23, 8'h7E)));
    end else begin
      line_buf.push_back(8'($urandom_range(8'h80, 8'hFF)));
    end
  endtask

  // mostly well-formed reports with random content, the rest broken lines and noise
  task build_random_line;
    int r, tower, fields, keep, tower_at, f, cut;
    line_buf.delete();
    r = $urandom_range(99);
    if (r >= 85) begin
      repeat ($urandom_range(1, 40)) line_buf.push_back(8'($urandom_range(255)));
      return;
    end

    repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
    // a false start on the prefix now and then
    if ($urandom_range(9) == 0) add_text("+CE");
    add_text("+CENG:");
    line_buf.push_back(($urandom_range(4) != 0) ? 8'h20 : 8'($urandom_range(1, 255)));
    tower = ($urandom_range(99) < 45) ? 0 : $urandom_range(1, DEF_TOWER_SLOTS - 1);
    tower_at = line_buf.size();
    line_buf.push_back(CHAR_ZERO + 8'(tower));
    if ($urandom_range(3) != 0) line_buf.push_back(CHAR_COMMA);
    else repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(8'h23, 8'h7E)));
    line_buf.push_back(CHAR_QUOTE);

    fields = (tower == 0) ? 11 : 7;
    keep   = ($urandom_range(9) == 0) ? $urandom_range(1, fields) : fields;
    for (f = 0; f < keep; f++) begin
      if (f > 0) begin
        line_buf.push_back(CHAR_COMMA);
        if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) line_buf.push_back(CHAR_COMMA);
      end
      // leading quotes before the last token are skipped
      if (f == fields - 1 && $urandom_range(9) == 0) line_buf.push_back(CHAR_QUOTE);
      add_token((tower == 0) ? (f == 6 || f == 9) : (f == 3 || f == 6));
      if (f == fields - 1 && $urandom_range(9) == 0) add_text(",12");
    end
    if (keep == fields && $urandom_range(7) != 0) line_buf.push_back(CHAR_QUOTE);
    if ($urandom_range(1) == 0) line_buf.push_back(8'h0D);
    // long tail saturates the byte count
    if ($urandom_range(39) == 0) repeat (240) line_buf.push_back(8'h0D);

    if (r >= 70) begin
      case ($urandom_range(4))
        0: begin
          case ($urandom_range(3))
            0:       line_buf[tower_at] = "/";
            1:       line_buf[tower_at] = CHAR_ZERO + 8'(DEF_TOWER_SLOTS);
            2:       line_buf[tower_at] = 8'hFF;
            default: line_buf[tower_at] = 8'h00;
          endcase
        end
        1: line_buf.insert($urandom_range(line_buf.size() - 1), 8'h00);
        2: line_buf[tower_at - 4] = "n";
        3: begin
          cut = $urandom_range(1, 14);
          while (line_buf.size() > cut) void'(line_buf.pop_back());
        end
        default: repeat ($urandom_range(44, 60)) line_buf.push_front("x");
      endcase
    end
  endtask

  initial begin
    int n_lines;
    rst                  = 1'b1;
    line_ch.valid        = 1'b0;
    line_ch.line_byte    = 8'h00;
    line_ch.line_last    = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.report_enable = 1'b0;
    rec_ch.ready         = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: typical serving line, the same again, then the last neighbour slot
    write_report_enable(1'b1);
    send_text("+CENG: 0,\"0517,42,37,460,00,1c,1a2b,51,00,247d,03\"");
    send_text("+CENG: 0,\"0517,42,37,460,00,1c,1a2b,51,00,247d,03\"");
    send_text("+CENG: 6,\"0600,30,1f,FFFFFFFF,70000,255,abcd\"");
    settle_records();
    write_report_enable(1'b0);
    send_text("+CENG: 6,\"0600,0,1f,0,0,128,0\"");
    // short line, missing prefix, bad index digits
    send_text("+CENG: 0,\"1\"");
    send_text("+CGNG: 0,\"0517,42,37,460\"");
    send_text("+CENG: 7,\"1,2,3,4,5,6,7\"");
    send_text("+CENG: /,\"1,2,3,4,5,6,7\"");
    // prefix ending on the last byte of the window, then one byte too late
    line_buf.delete();
    repeat (DEF_PREFIX_WINDOW - 6) line_buf.push_back("x");
    add_text("+CENG: 1,\"5,99,2a,ffff,310,26,7\"");
    send_line();
    line_buf.delete();
    repeat (DEF_PREFIX_WINDOW - 5) line_buf.push_back("x");
    add_text("+CENG: 1,\"5,99,2a,ffff,310,26,7\"");
    send_line();
    // zero byte before the index, and one within a token
    line_buf.delete();
    add_text("+CENG: ");
    line_buf.push_back(8'h00);
    add_text("0,\"1,2,3,4,5,6\"");
    send_line();
    line_buf.delete();
    add_text("+CENG: 0,\"0517,42,37,46");
    line_buf.push_back(8'h00);
    add_text("0,00,1c\"");
    send_line();
    // missing tokens, comma runs, hex junk, wrapping decimals, quoted commas in ta
    send_text("+CENG: 3,\"12,34\"");
    send_text("+CENG: 0,\"1,,,999,7,,99999999999,300,9,x1-2g3,12,34,\"\"5,6\"");
    line_buf.delete();
    add_text("+CENG: 1,\"1,");
    line_buf.push_back(8'hE0);
    add_text("5,2f,460,7,ffff\"");
    send_line();
    // no closing quote, a one-byte line, an overlong line
    send_text("+CENG: 2,\"10,20,30,c0de,310,260,beef");
    send_text("+");
    line_buf.delete();
    add_text("+CENG: 0,\"0517,0,37,65535,255,1c,0,51,00,ffff,65535\"");
    repeat (240) line_buf.push_back(8'h0D);
    send_line();
    settle_records();
    write_report_enable(1'b1);

    // random lines; a calm stretch with no idling on either side, and regular
    // pauses to drain the records and move the enable
    n_lines = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      calm = (n_lines >= 1 && n_lines < 6);
      build_random_line();
      send_line();
      n_lines++;
      if (n_lines % 8 == 7) begin
        settle_records();
        write_report_enable(1'($urandom_range(1)));
      end
    end
    calm = 1'b0;

    settle_records();
    repeat (10) @(negedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/crlp_pkg.sv
hw/rtl/crlp_if.sv
hw/rtl/crlp_front.sv
hw/rtl/crlp_queue.sv
hw/rtl/crlp_back.sv
hw/rtl/cell_report_line_parser.sv
hw/rtl/crlp_checker.sv
tb/sv/crlp_record_checker.sv
tb/sv/cell_report_line_parser_tb.sv
